// ----- hdl/xcpr_pkg.sv -----
// Package for the XOR-checked packet receiver.
// Holds the shared widths, register indexes and the frame record passed from
// the parser to the top level. Depends on nothing.
package xcpr_pkg;

  localparam int unsigned ADC_BITS       = 10;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned FS_W           = 12;
  localparam int unsigned ADC_W          = 16;
  localparam int unsigned MV_W           = 18;
  localparam int unsigned PROD_W         = ADC_W + FS_W;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [BYTE_W-1:0] MIN_LENGTH     = 8'd4;
  localparam logic [BYTE_W-1:0] POT_MIN_LENGTH = 8'd6;

  localparam logic [BYTE_W-1:0] START_MARKER_RST  = 8'd170;
  localparam logic [BYTE_W-1:0] POT_CODE_RST      = 8'd80;
  localparam logic [FS_W-1:0]   FULL_SCALE_MV_RST = 12'd3300;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARKER  = 2'd0,
    CFG_POT_CODE      = 2'd1,
    CFG_FULL_SCALE_MV = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] packet_length;
    logic [BYTE_W-1:0] command_byte;
    logic              is_pot_reading;
    logic [ADC_W-1:0]  adc_value;
  } frame_t;

endpackage

// ----- hdl/xcpr_parser.sv -----
// Byte-level packet parser: start hunt, length check, running XOR and field
// capture. Produces a completed frame record on the checksum byte.
// Depends on xcpr_pkg.
module xcpr_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [xcpr_pkg::BYTE_W-1:0] rx_byte,
  input  logic [xcpr_pkg::BYTE_W-1:0] start_marker,
  input  logic [xcpr_pkg::BYTE_W-1:0] pot_code,
  output logic                        frame_done,
  output xcpr_pkg::frame_t            frame
);
  import xcpr_pkg::*;

  logic [BYTE_W-1:0] byte_index_r, byte_index_nxt;
  logic [BYTE_W-1:0] exp_len_r, exp_len_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] high_r, high_nxt;
  logic [BYTE_W-1:0] low_r, low_nxt;
  logic              in_body;
  logic              good;
  logic              has_adc;

  assign in_body = ({1'b0, byte_index_r} + 9'd1) < {1'b0, exp_len_r};
  assign good    = (rx_byte == xor_r);
  assign has_adc = (exp_len_r >= POT_MIN_LENGTH);

  always_comb begin
    byte_index_nxt = byte_index_r;
    exp_len_nxt    = exp_len_r;
    xor_nxt        = xor_r;
    cmd_nxt        = cmd_r;
    high_nxt       = high_r;
    low_nxt        = low_r;
    frame_done     = 1'b0;
    if (accept) begin
      priority if (byte_index_r == 8'd0) begin
        if (rx_byte == start_marker) begin
          xor_nxt        = rx_byte;
          byte_index_nxt = 8'd1;
        end
      end else if (byte_index_r == 8'd1) begin
        if (rx_byte < MIN_LENGTH) begin
          byte_index_nxt = 8'd0;
        end else begin
          exp_len_nxt    = rx_byte;
          xor_nxt        = xor_r ^ rx_byte;
          byte_index_nxt = 8'd2;
        end
      end else if (in_body) begin
        if (byte_index_r == 8'd2) begin
          cmd_nxt = rx_byte;
        end
        if (byte_index_r == 8'd3) begin
          high_nxt = rx_byte;
        end
        if (byte_index_r == 8'd4) begin
          low_nxt = rx_byte;
        end
        xor_nxt        = xor_r ^ rx_byte;
        byte_index_nxt = byte_index_r + 8'd1;
      end else begin
        frame_done     = 1'b1;
        byte_index_nxt = 8'd0;
      end
    end
  end

  always_comb begin
    frame.status         = ~good;
    frame.packet_length  = exp_len_r;
    frame.command_byte   = cmd_r;
    frame.is_pot_reading = good & has_adc & (cmd_r == pot_code);
    frame.adc_value      = has_adc ? {high_r, low_r} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      exp_len_r    <= MIN_LENGTH;
      xor_r        <= '0;
    end else begin
      byte_index_r <= byte_index_nxt;
      exp_len_r    <= exp_len_nxt;
      xor_r        <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    high_r <= high_nxt;
    low_r  <= low_nxt;
  end

endmodule

// ----- hdl/xor_checked_packet_receiver.sv -----
// Top level of the XOR-checked packet receiver.
// Holds the configuration registers, the frame stage and the millivolt output
// stage. Depends on xcpr_pkg and xcpr_parser.

// One received byte is taken per request in every cycle unless in_stall is
// high. A checksum byte passes the frame stage, which holds the parser's
// frame record, then the output stage, which stores it with the ADC value
// times the full-scale setting as shifted, saturated millivolts. Both stages
// advance unless the output stalls; bytes stall only when both are full.
// Configuration writes are always taken and should be made only while idle.
module xor_checked_packet_receiver (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [xcpr_pkg::BYTE_W-1:0]    in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_status,
  output logic [xcpr_pkg::BYTE_W-1:0]    out_packet_length,
  output logic [xcpr_pkg::BYTE_W-1:0]    out_command_byte,
  output logic                           out_is_pot_reading,
  output logic [xcpr_pkg::ADC_W-1:0]     out_adc_value,
  output logic [xcpr_pkg::MV_W-1:0]      out_millivolts,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [xcpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xcpr_pkg::FS_W-1:0]      cfg_data
);
  import xcpr_pkg::*;

  logic [BYTE_W-1:0] start_marker_r;
  logic [BYTE_W-1:0] pot_code_r;
  logic [FS_W-1:0]   full_scale_r;

  logic              accept;
  logic              frame_done;
  frame_t            frame;
  logic              a_valid_r;
  frame_t            a_frame_r;
  logic              a_advance;
  logic              out_valid_r;
  frame_t            out_frame_r;
  logic [MV_W-1:0]   out_mv_r;
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] scaled;
  logic [MV_W-1:0]   mv_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = a_valid_r & out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign a_advance = a_valid_r & ~(out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      pot_code_r     <= POT_CODE_RST;
      full_scale_r   <= FULL_SCALE_MV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_START_MARKER:  start_marker_r <= cfg_data[BYTE_W-1:0];
        CFG_POT_CODE:      pot_code_r     <= cfg_data[BYTE_W-1:0];
        CFG_FULL_SCALE_MV: full_scale_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  xcpr_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .rx_byte      (in_rx_byte),
    .start_marker (start_marker_r),
    .pot_code     (pot_code_r),
    .frame_done   (frame_done),
    .frame        (frame)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (accept && frame_done) begin
      a_valid_r <= 1'b1;
    end else if (a_advance) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_done) begin
      a_frame_r <= frame;
    end
  end

  assign product = PROD_W'(a_frame_r.adc_value) * PROD_W'(full_scale_r);
  assign scaled  = product >> ADC_BITS;
  assign mv_sat  = (scaled > PROD_W'({MV_W{1'b1}})) ? {MV_W{1'b1}} : scaled[MV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      out_frame_r <= a_frame_r;
      out_mv_r    <= mv_sat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_frame_r.status;
  assign out_packet_length  = out_frame_r.packet_length;
  assign out_command_byte   = out_frame_r.command_byte;
  assign out_is_pot_reading = out_frame_r.is_pot_reading;
  assign out_adc_value      = out_frame_r.adc_value;
  assign out_millivolts     = out_mv_r;

endmodule

// ----- hdl/xcpr_checker.sv -----
// Port-level checker for the XOR-checked packet receiver, with its bind.
// Watches the top-level ports only. Depends on xcpr_pkg.
module xcpr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_status,
  input logic [xcpr_pkg::BYTE_W-1:0] out_packet_length,
  input logic [xcpr_pkg::BYTE_W-1:0] out_command_byte,
  input logic                        out_is_pot_reading,
  input logic [xcpr_pkg::ADC_W-1:0]  out_adc_value,
  input logic [xcpr_pkg::MV_W-1:0]   out_millivolts
);
  import xcpr_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_adc_value)
      && $stable(out_millivolts) && $stable(out_command_byte))
    else $error("Stalled result changed.");

  a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_packet_length >= MIN_LENGTH)
    else $error("Result with a length below the minimum.");

  a_pot_needs_good: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_pot_reading |-> !out_status
      && out_packet_length >= POT_MIN_LENGTH)
    else $error("Pot reading flagged on a bad or short packet.");

  a_short_no_adc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_length < POT_MIN_LENGTH
      |-> out_adc_value == '0 && out_millivolts == '0)
    else $error("Short packet reported ADC data.");

endmodule

bind xor_checked_packet_receiver xcpr_checker u_xcpr_checker (.*);

// ----- verif/xcpr_frame_monitor.sv -----
// Frame monitor for the XOR-checked packet receiver: watches the byte, result
// and register channels, predicts every frame and compares it field by field.
// Depends on xcpr_pkg.
module xcpr_frame_monitor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [xcpr_pkg::BYTE_W-1:0]    in_rx_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_status,
  input  logic [xcpr_pkg::BYTE_W-1:0]    out_packet_length,
  input  logic [xcpr_pkg::BYTE_W-1:0]    out_command_byte,
  input  logic                           out_is_pot_reading,
  input  logic [xcpr_pkg::ADC_W-1:0]     out_adc_value,
  input  logic [xcpr_pkg::MV_W-1:0]      out_millivolts,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [xcpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [xcpr_pkg::FS_W-1:0]      cfg_data,
  output int                             mismatches,
  output int                             frames_checked,
  output int                             frames_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import xcpr_pkg::*;

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] packet_length;
    logic [BYTE_W-1:0] command_byte;
    logic              is_pot_reading;
    logic [ADC_W-1:0]  adc_value;
    logic [MV_W-1:0]   millivolts;
  } frame_fields_t;

  localparam logic [MV_W-1:0] MV_CEIL = '1;

  logic [BYTE_W-1:0] hunt_pos;
  logic [BYTE_W-1:0] frame_len;
  logic [BYTE_W-1:0] xor_acc;
  logic [BYTE_W-1:0] cmd_hold;
  logic [BYTE_W-1:0] adc_hi;
  logic [BYTE_W-1:0] adc_lo;
  logic [BYTE_W-1:0] start_code;
  logic [BYTE_W-1:0] pot_cmd;
  logic [FS_W-1:0]   full_scale;

  frame_fields_t frames_due[$];
  frame_fields_t due;
  frame_fields_t seen;
  frame_fields_t fresh;

  function automatic bit advance_frame(input logic [BYTE_W-1:0] b,
                                       output frame_fields_t res);
    logic              good;
    logic              has_adc;
    logic [ADC_W-1:0]  adc;
    logic [PROD_W-1:0] scaled;
    res = '0;
    advance_frame = 1'b0;
    if (hunt_pos == 0) begin
      if (b == start_code) begin
        xor_acc = b;
        hunt_pos = 1;
      end
    end else if (hunt_pos == 1) begin
      if (b < MIN_LENGTH) begin
        hunt_pos = 0;
      end else begin
        frame_len = b;
        xor_acc = xor_acc ^ b;
        hunt_pos = 2;
      end
    end else if (int'(hunt_pos) + 1 < int'(frame_len)) begin
      if (hunt_pos == 2) begin
        cmd_hold = b;
      end else if (hunt_pos == 3) begin
        adc_hi = b;
      end else if (hunt_pos == 4) begin
        adc_lo = b;
      end
      xor_acc = xor_acc ^ b;
      hunt_pos = hunt_pos + 1;
    end else begin
      good = (b == xor_acc);
      has_adc = (frame_len >= POT_MIN_LENGTH);
      adc = has_adc ? {adc_hi, adc_lo} : '0;
      scaled = (PROD_W'(adc) * PROD_W'(full_scale)) >> ADC_BITS;
      res.status = !good;
      res.packet_length = frame_len;
      res.command_byte = cmd_hold;
      res.is_pot_reading = good && has_adc && (cmd_hold == pot_cmd);
      res.adc_value = adc;
      res.millivolts = (scaled > PROD_W'(MV_CEIL)) ? MV_CEIL : scaled[MV_W-1:0];
      hunt_pos = 0;
      advance_frame = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hunt_pos = '0;
      frame_len = MIN_LENGTH;
      xor_acc = '0;
      cmd_hold = '0;
      adc_hi = '0;
      adc_lo = '0;
      start_code = START_MARKER_RST;
      pot_cmd = POT_CODE_RST;
      full_scale = FULL_SCALE_MV_RST;
      frames_due.delete();
      mismatches = 0;
      frames_checked = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen.status = out_status;
        seen.packet_length = out_packet_length;
        seen.command_byte = out_command_byte;
        seen.is_pot_reading = out_is_pot_reading;
        seen.adc_value = out_adc_value;
        seen.millivolts = out_millivolts;
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with none outstanding: status=%0d len=%0d cmd=%0h",
                     $realtime, seen.status, seen.packet_length, seen.command_byte);
          end
        end else begin
          due = frames_due.pop_front();
          frames_checked++;
          if (seen.status !== due.status || seen.packet_length !== due.packet_length ||
              seen.command_byte !== due.command_byte ||
              seen.is_pot_reading !== due.is_pot_reading ||
              seen.adc_value !== due.adc_value || seen.millivolts !== due.millivolts) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: frame %0d exp st=%0d len=%0d cmd=%0h pot=%0d adc=%0h mv=%0d",
                       $realtime, frames_checked, due.status, due.packet_length,
                       due.command_byte, due.is_pot_reading, due.adc_value, due.millivolts);
              $display("%0t: frame %0d act st=%0d len=%0d cmd=%0h pot=%0d adc=%0h mv=%0d",
                       $realtime, frames_checked, seen.status, seen.packet_length,
                       seen.command_byte, seen.is_pot_reading, seen.adc_value,
                       seen.millivolts);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_START_MARKER:  start_code = cfg_data[BYTE_W-1:0];
          CFG_POT_CODE:      pot_cmd = cfg_data[BYTE_W-1:0];
          CFG_FULL_SCALE_MV: full_scale = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (advance_frame(in_rx_byte, fresh)) begin
          frames_due.push_back(fresh);
        end
      end
    end
    frames_pending = frames_due.size();
  end

endmodule

// ----- verif/xor_checked_packet_receiver_tb.sv -----
// Testbench top for the XOR-checked packet receiver: drives bytes, register
// writes and output stalls, and reports the verdict of the frame monitor.
// Depends on xcpr_pkg, xcpr_frame_monitor and the receiver RTL.
module xor_checked_packet_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xcpr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_BYTES = 260;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_status;
  logic [BYTE_W-1:0]    out_packet_length;
  logic [BYTE_W-1:0]    out_command_byte;
  logic                 out_is_pot_reading;
  logic [ADC_W-1:0]     out_adc_value;
  logic [MV_W-1:0]      out_millivolts;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_idx_t             cfg_index = CFG_START_MARKER;
  logic [FS_W-1:0]      cfg_data = '0;

  int                   mismatches;
  int                   frames_checked;
  int                   frames_pending;
  int                   cycle_count = 0;
  int                   bytes_sent = 0;
  int                   settings_used = 1;
  int                   stall_left = 0;
  int                   out_draw;
  bit                   in_burst = 1'b0;
  bit                   out_burst = 1'b0;
  logic [BYTE_W-1:0]    cur_start = START_MARKER_RST;
  logic [BYTE_W-1:0]    cur_pot = POT_CODE_RST;

  xor_checked_packet_receiver i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_packet_length  (out_packet_length),
    .out_command_byte   (out_command_byte),
    .out_is_pot_reading (out_is_pot_reading),
    .out_adc_value      (out_adc_value),
    .out_millivolts     (out_millivolts),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  xcpr_frame_monitor i_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_packet_length  (out_packet_length),
    .out_command_byte   (out_command_byte),
    .out_is_pot_reading (out_is_pot_reading),
    .out_adc_value      (out_adc_value),
    .out_millivolts     (out_millivolts),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .frames_checked     (frames_checked),
    .frames_pending     (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d frames outstanding.", frames_pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      out_burst <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) begin
        out_burst <= ~out_burst;
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end else if (out_valid && !out_stall) begin
        out_draw = out_burst ? 0 : $urandom_range(0, 10);
        stall_left <= out_draw;
        out_stall <= (out_draw != 0);
      end
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // A fill of -1 gives random payload bytes; keep cuts the packet short.
  task automatic send_packet(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] cmd,
                             input bit corrupt, input int keep, input int fill);
    logic [BYTE_W-1:0] chk;
    logic [BYTE_W-1:0] b;
    int                n;
    n = (len < MIN_LENGTH) ? 2 : int'(len);
    chk = '0;
    for (int i = 0; i < n && i < keep; i++) begin
      if (i == 0) begin
        b = cur_start;
      end else if (i == 1) begin
        b = len;
      end else if (i == 2) begin
        b = cmd;
      end else if (i == n - 1) begin
        b = corrupt ? chk ^ BYTE_W'($urandom_range(1, 255)) : chk;
      end else begin
        b = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
      end
      chk = chk ^ b;
      send_byte(b);
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [FS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [BYTE_W-1:0] start_val,
                                input logic [BYTE_W-1:0] pot_val,
                                input logic [FS_W-1:0] fs_val);
    write_reg(CFG_START_MARKER, {4'($urandom), start_val});
    write_reg(CFG_POT_CODE, {4'($urandom), pot_val});
    write_reg(CFG_FULL_SCALE_MV, fs_val);
    write_reg(CFG_UNUSED, FS_W'($urandom));
    cfg_valid <= 1'b0;
    cur_start = start_val;
    cur_pot = pot_val;
    settings_used++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase(input int budget);
    int                limit;
    int                pick;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] cmd;
    limit = bytes_sent + budget;
    while (bytes_sent < limit) begin
      if ($urandom_range(0, 7) == 0) begin
        in_burst = ~in_burst;
      end
      pick = $urandom_range(0, 99);
      len = ($urandom_range(0, 39) == 0) ? BYTE_W'($urandom_range(13, 255))
                                         : BYTE_W'($urandom_range(4, 12));
      cmd = $urandom_range(0, 1) ? cur_pot : BYTE_W'($urandom);
      if (pick < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom));
      end else if (pick < 12) begin
        send_packet(BYTE_W'($urandom_range(0, 3)), cmd, 1'b0, 255, -1);
      end else if (pick < 16) begin
        send_packet(len, cmd, 1'b0, $urandom_range(2, int'(len) - 1), -1);
      end else begin
        send_packet(len, cmd, $urandom_range(0, 3) == 0, 255, -1);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_packet(8'd3, 8'h00, 1'b0, 255, -1);
    send_packet(8'd0, 8'h00, 1'b0, 255, -1);
    send_packet(8'd4, 8'h00, 1'b0, 255, -1);
    send_packet(8'd5, POT_CODE_RST, 1'b1, 255, -1);
    send_packet(8'd6, POT_CODE_RST, 1'b0, 255, 8'hFF);
    send_packet(8'd7, POT_CODE_RST, 1'b1, 255, 8'h00);
    settle();

    apply_settings(8'd255, 8'd255, 12'd4095);
    random_phase(PHASE_BYTES);
    settle();
    apply_settings(8'd0, 8'd0, 12'd0);
    random_phase(PHASE_BYTES);
    settle();
    apply_settings(START_MARKER_RST, POT_CODE_RST, 12'd1);
    random_phase(PHASE_BYTES);
    settle();
    repeat (3) begin
      apply_settings(BYTE_W'($urandom), BYTE_W'($urandom), FS_W'($urandom));
      random_phase(PHASE_BYTES);
      settle();
    end

    $display("Sent %0d bytes under %0d register settings; %0d frames compared, %0d mismatches.",
             bytes_sent, settings_used, frames_checked, mismatches);
    if (mismatches == 0 && frames_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
